// ===== rtl/p1_telegram_deframer_unit_assert.svh =====
// Assertion macros for the P1 telegram deframer checker.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef P1_TELEGRAM_DEFRAMER_UNIT_ASSERT_SVH
`define P1_TELEGRAM_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define P1DF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("p1df assertion failed");

// Next-cycle implication, disabled during reset
`define P1DF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("p1df assertion failed");

// Next-cycle implication, checked during reset as well
`define P1DF_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("p1df assertion failed");

`endif

// ===== rtl/p1df_pkg.sv =====
// Shared types and constants for the P1 telegram deframer.
// No dependencies; used by the step logic and the top level.
package p1df_pkg;

  localparam int OFS_W  = 12;   // write offset and address width
  localparam int FAIL_W = 17;   // saturating fail counter width

  localparam logic [7:0] CH_OPEN = 8'h2F;  // '/'
  localparam logic [7:0] CH_BANG = 8'h21;  // '!'
  localparam logic [7:0] CH_CR   = 8'h0D;  // carriage return

  localparam logic [2:0] TAIL_OLD_LEN = 3'd2;
  localparam logic [2:0] TAIL_NEW_LEN = 3'd6;
  localparam logic [2:0] TAIL_FIFTH   = 3'd4;

  // configuration register indexes
  localparam logic CFG_FRAME_LIMIT = 1'b0;
  localparam logic CFG_FAIL_LIMIT  = 1'b1;

  localparam logic [11:0] FRAME_LIMIT_RST = 12'd1024;
  localparam logic [15:0] FAIL_LIMIT_RST  = 16'd1024;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_TAIL = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_OLD_DONE = 3'd1,
    EV_NEW_DONE = 3'd2,
    EV_BAD_TAIL = 3'd3,
    EV_OVERFLOW = 3'd4
  } event_t;

  typedef struct packed {
    phase_t              phase;
    logic [OFS_W-1:0]    write_offset;
    logic [2:0]          tail_count;
    logic                first_tail_is_cr;
    logic [FAIL_W-1:0]   fail_count;
  } state_t;

  typedef struct packed {
    logic             store_valid;
    logic [11:0]      store_addr;
    logic [7:0]       store_byte;
    event_t           event_res;
    logic [11:0]      frame_length;
    logic             give_up;
  } result_t;

endpackage

// ===== rtl/p1df_step.sv =====
// Per-byte deframing logic: next state and result for one received byte.
// Purely combinational; depends on p1df_pkg.
module p1df_step import p1df_pkg::*; (
  input  state_t            cur,
  input  logic [7:0]        rx_byte,
  input  logic [OFS_W-1:0]  limit,
  input  logic [15:0]       fail_limit,
  output state_t            nxt,
  output result_t           res
);

  logic                  in_limit;
  logic                  is_cr;
  logic [2:0]            tail_inc;
  logic                  ftc_upd;
  logic                  old_done;
  logic                  new_done;
  logic                  bad_tail;
  logic                  overflow;
  logic                  done;
  logic [OFS_W:0]        fail_add;
  logic [FAIL_W:0]       fail_sum;
  logic [FAIL_W-1:0]     fail_nx;
  logic                  give_up;

  // Shared decode of the current byte and state
  assign in_limit = cur.write_offset < limit;
  assign is_cr    = rx_byte == CH_CR;
  assign tail_inc = cur.tail_count + 3'd1;
  assign ftc_upd  = (cur.tail_count == 3'd0 || cur.tail_count == TAIL_FIFTH) ?
                    is_cr : cur.first_tail_is_cr;
  assign old_done = cur.phase == PH_TAIL && tail_inc == TAIL_OLD_LEN && ftc_upd;
  assign new_done = cur.phase == PH_TAIL && !old_done && tail_inc >= TAIL_NEW_LEN
                    && ftc_upd;
  assign bad_tail = cur.phase == PH_TAIL && !old_done && tail_inc >= TAIL_NEW_LEN
                    && !ftc_upd;
  assign overflow = cur.phase == PH_BODY && !in_limit;
  assign done     = old_done || new_done;

  // Saturating fail count after this byte
  assign fail_add = bad_tail ? ({1'b0, cur.write_offset} + (OFS_W+1)'(TAIL_NEW_LEN)) :
                    overflow ? {1'b0, cur.write_offset} : '0;
  assign fail_sum = {1'b0, cur.fail_count} + (FAIL_W+1)'(fail_add);
  assign fail_nx  = fail_sum[FAIL_W] ? '1 : fail_sum[FAIL_W-1:0];
  assign give_up  = !done && fail_limit != 16'd0 &&
                    fail_nx >= FAIL_W'(fail_limit);

  // Next state
  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      PH_HUNT: begin
        if (rx_byte == CH_OPEN) begin
          nxt.phase        = PH_BODY;
          nxt.write_offset = OFS_W'(1);
        end
      end
      PH_BODY: begin
        if (in_limit) begin
          nxt.write_offset = cur.write_offset + OFS_W'(1);
          if (rx_byte == CH_BANG) begin
            nxt.phase            = PH_TAIL;
            nxt.tail_count       = 3'd0;
            nxt.first_tail_is_cr = 1'b0;
          end
        end else begin
          nxt            = '0;
          nxt.fail_count = fail_nx;
        end
      end
      PH_TAIL: begin
        nxt.tail_count       = tail_inc;
        nxt.first_tail_is_cr = ftc_upd;
        if (bad_tail) begin
          nxt            = '0;
          nxt.fail_count = fail_nx;
        end
      end
      default: begin
        nxt = '0;
      end
    endcase
    // Frame done or give-up returns everything to reset
    if (done || give_up) begin
      nxt = '0;
    end
  end

  // Result
  always_comb begin
    res = '0;
    unique case (cur.phase)
      PH_HUNT: begin
        if (rx_byte == CH_OPEN) begin
          res.store_valid = 1'b1;
          res.store_byte  = rx_byte;
        end
      end
      PH_BODY: begin
        if (in_limit) begin
          res.store_valid = 1'b1;
          res.store_addr  = cur.write_offset;
          res.store_byte  = rx_byte;
        end else begin
          res.event_res = EV_OVERFLOW;
        end
      end
      PH_TAIL: begin
        res.store_valid = 1'b1;
        res.store_addr  = cur.write_offset + OFS_W'(cur.tail_count);
        res.store_byte  = rx_byte;
        if (old_done) begin
          res.event_res    = EV_OLD_DONE;
          res.frame_length = cur.write_offset + OFS_W'(TAIL_OLD_LEN);
        end else if (new_done) begin
          res.event_res    = EV_NEW_DONE;
          res.frame_length = cur.write_offset + OFS_W'(TAIL_NEW_LEN);
        end else if (bad_tail) begin
          res.event_res = EV_BAD_TAIL;
        end
      end
      default: begin
        res = '0;
      end
    endcase
    res.give_up = give_up;
  end

endmodule

// ===== rtl/p1_telegram_deframer_unit.sv =====
// P1 telegram deframer top level: input register, step logic, result register.
// Depends on p1df_pkg and p1df_step.
//
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) carries one received byte per
//   request. Output channel (out_valid, out_stall, store_*, event_res,
//   frame_length, give_up) returns exactly one result per byte, in order.
//   Configuration: pulse cfg_write with cfg_index (0 frame_limit, 1 fail_limit)
//   and cfg_data; write only while no byte is in flight.
// Path: a byte accepted into the input register passes through the step logic into
//   the result register once that register is free, and is then on the output.
// Throughput: one byte per cycle while out_stall is low; the frame state is updated
//   by one short compare-and-count step between the input and result registers.
// Stall: when out_stall holds a result, the result register keeps it and the
//   input register fills; in_stall rises once both are occupied, and no
//   request is lost or repeated.
// Reset: rst (synchronous) empties both registers, sets both limits to 1024,
//   and returns the deframer to hunting for '/' with a zero fail count.
// A give-up (fail count reached fail_limit) returns the frame state to reset
//   but keeps the configuration registers.
module p1_telegram_deframer_unit import p1df_pkg::*; #(
  parameter int BUFFER_DEPTH = 2048
) (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_write,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  // input channel
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   rx_byte,
  // output channel
  output logic         out_valid,
  input  logic         out_stall,
  output logic         store_valid,
  output logic [11:0]  store_addr,
  output logic [7:0]   store_byte,
  output logic [2:0]   event_res,
  output logic [11:0]  frame_length,
  output logic         give_up
);

  localparam int OfsMax = (1 << OFS_W) - 1;
  localparam logic [OFS_W-1:0] LimCap =
    (BUFFER_DEPTH > OfsMax) ? OFS_W'(OfsMax) : OFS_W'(BUFFER_DEPTH);

  logic [11:0]       frame_limit;
  logic [15:0]       fail_limit;
  logic [OFS_W-1:0]  limit;
  logic              in_full;
  logic [7:0]        in_byte;
  logic              advance;
  state_t            state;
  state_t            state_next;
  result_t           res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= FRAME_LIMIT_RST;
      fail_limit  <= FAIL_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_LIMIT: frame_limit <= cfg_data[11:0];
        CFG_FAIL_LIMIT:  fail_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the frame limit to one and the buffer depth
  assign limit = (frame_limit == '0) ? OFS_W'(1) :
                 (frame_limit > LimCap) ? LimCap : frame_limit;

  // Handshake: the result register frees when empty or taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  p1df_step u_step (
    .cur        (state),
    .rx_byte    (in_byte),
    .limit      (limit),
    .fail_limit (fail_limit),
    .nxt        (state_next),
    .res        (res)
  );

  // Frame state: advance when a byte moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_full && advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_full && advance) begin
      out_valid <= 1'b1;
    end else if (advance) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_full && advance) begin
      store_valid  <= res.store_valid;
      store_addr   <= res.store_addr;
      store_byte   <= res.store_byte;
      event_res    <= res.event_res;
      frame_length <= res.frame_length;
      give_up      <= res.give_up;
    end
  end

endmodule

// ===== rtl/p1df_checker.sv =====
// Port-level checker for the P1 telegram deframer, bound to the top level.
// Depends on p1df_pkg and p1_telegram_deframer_unit_assert.svh.
`include "p1_telegram_deframer_unit_assert.svh"

module p1df_checker import p1df_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_stall,
  input logic         out_valid,
  input logic         out_stall,
  input logic         store_valid,
  input logic [11:0]  store_addr,
  input logic [7:0]   store_byte,
  input logic [2:0]   event_res,
  input logic [11:0]  frame_length,
  input logic         give_up
);

  logic frame_done;
  logic overflow_ev;

  // Decode the completed-frame and overflow events
  assign frame_done  = event_res == EV_OLD_DONE || event_res == EV_NEW_DONE;
  assign overflow_ev = event_res == EV_OVERFLOW;

  // Hold a stalled result
  `P1DF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(store_addr) && $stable(store_byte) && $stable(event_res))

  // Reset empties the result register
  `P1DF_ASSERT_NEXT_ALWAYS(a_rst_empty, rst, !out_valid)

  // Skipped bytes carry zero address and data
  `P1DF_ASSERT_IMPLY(a_no_store_zero, out_valid && !store_valid, store_addr == 12'd0 && store_byte == 8'd0)

  // Completed frames store their last byte and never give up
  `P1DF_ASSERT_IMPLY(a_done_store, out_valid && frame_done, store_valid && !give_up)

  // Frame length only comes with a completed frame; overflow drops the byte
  `P1DF_ASSERT_IMPLY(a_len_only_done, out_valid && !frame_done, frame_length == 12'd0 && (!overflow_ev || !store_valid))

endmodule

bind p1_telegram_deframer_unit p1df_checker u_p1df_checker (.*);

// ===== dv/tb_p1_telegram_deframer_unit.sv =====
// Self-checking testbench for p1_telegram_deframer_unit: a byte-level frame predictor
// checks every result of a directed table and random frame traffic.
// Depends on p1df_pkg and the deframer RTL only.
module tb_p1_telegram_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import p1df_pkg::*;

  localparam int BUF_DEPTH     = 2048;
  localparam int QUIET_LIMIT   = 1000;
  localparam int REPORT_CAP    = 60;
  localparam int SETTLE_CYCLES = 6;
  localparam int FAIL_SAT      = 17'h1FFFF;
  localparam int ITEMS_PER_SET = 40;

  localparam logic [15:0] FRAME_SETTINGS [9] = '{16'd12, 16'd1, 16'hFFFF, 16'd3, 16'd2048,
                                                 16'd8, 16'd6, 16'd1, 16'd20};
  localparam logic [15:0] FAIL_SETTINGS  [9] = '{16'd40, 16'd3, 16'd0, 16'hFFFF, 16'd5,
                                                 16'd1, 16'hFFFF, 16'd0, 16'd4};

  typedef struct packed {
    bit          is_cfg;
    logic        idx;
    logic [15:0] val;
    logic [7:0]  b;
    bit          typed;
    result_t     want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        store_valid;
  logic [11:0] store_addr;
  logic [7:0]  store_byte;
  logic [2:0]  event_res;
  logic [11:0] frame_length;
  logic        give_up;

  // predictor copy of the registers and the frame state
  logic [11:0] frame_limit_reg;
  logic [15:0] fail_limit_reg;
  phase_t      ph;
  logic [11:0] wofs;
  logic [2:0]  tcnt;
  logic        tail_cr;
  logic [16:0] fail_cnt;

  result_t pending_results[$];
  row_t    directed_rows[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      bytes_sent = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  int      give_ups = 0;
  int      ev_tally[5] = '{0, 0, 0, 0, 0};

  p1_telegram_deframer_unit #(.BUFFER_DEPTH(BUF_DEPTH)) DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // clamp the frame limit to 1..buffer depth
  function automatic int eff_limit();
    int lim;
    lim = int'(frame_limit_reg);
    if (lim < 1) lim = 1;
    if (lim > BUF_DEPTH) lim = BUF_DEPTH;
    return lim;
  endfunction

  function automatic logic [7:0] pick_byte_except(input logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == avoid) ? (b ^ 8'h01) : b;
  endfunction

  task automatic hunt_again(input bit zero_fails);
    ph = PH_HUNT;
    wofs = '0;
    tcnt = '0;
    tail_cr = 1'b0;
    if (zero_fails) fail_cnt = '0;
  endtask

  // saturating add of discarded bytes
  task automatic count_fail(input int n);
    int sum;
    sum = int'(fail_cnt) + n;
    fail_cnt = (sum > FAIL_SAT) ? 17'(FAIL_SAT) : 17'(sum);
  endtask

  // advance the frame state by one byte and form its result
  task automatic deframe_byte(input logic [7:0] b, output result_t r);
    bit done;
    int lim;
    r = '0;
    done = 1'b0;
    lim = eff_limit();
    case (ph)
      PH_BODY: begin
        if (int'(wofs) < lim) begin
          r.store_valid = 1'b1;
          r.store_addr = wofs;
          r.store_byte = b;
          wofs = wofs + 12'd1;
          if (b == CH_BANG) begin
            ph = PH_TAIL;
            tcnt = '0;
            tail_cr = 1'b0;
          end
        end else begin
          r.event_res = EV_OVERFLOW;
          count_fail(int'(wofs));
          hunt_again(1'b0);
        end
      end
      PH_TAIL: begin
        r.store_valid = 1'b1;
        r.store_addr = wofs + 12'(tcnt);
        r.store_byte = b;
        // first tail byte picks the style; the fifth one sets the flag again
        if (tcnt == 3'd0 || tcnt == TAIL_FIFTH) tail_cr = (b == CH_CR);
        tcnt = tcnt + 3'd1;
        if (tcnt == TAIL_OLD_LEN && tail_cr) begin
          r.event_res = EV_OLD_DONE;
          r.frame_length = wofs + 12'd2;
          done = 1'b1;
        end else if (tcnt >= TAIL_NEW_LEN) begin
          if (tail_cr) begin
            r.event_res = EV_NEW_DONE;
            r.frame_length = wofs + 12'd6;
            done = 1'b1;
          end else begin
            r.event_res = EV_BAD_TAIL;
            count_fail(int'(wofs) + 6);
            hunt_again(1'b0);
          end
        end
      end
      default: begin
        if (b == CH_OPEN) begin
          r.store_valid = 1'b1;
          r.store_addr = '0;
          r.store_byte = b;
          wofs = 12'd1;
          ph = PH_BODY;
        end
      end
    endcase
    if (done) begin
      hunt_again(1'b1);
    end else if (fail_limit_reg != 16'd0 && fail_cnt >= 17'(fail_limit_reg)) begin
      r.give_up = 1'b1;
      hunt_again(1'b1);
    end
  endtask

  // drive one byte request, hold it until accepted, then log its expected result
  task automatic send_item(input logic [7:0] b, input bit typed = 1'b0,
                           input result_t want = '0);
    result_t r;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    deframe_byte(b, r);
    ev_tally[int'(r.event_res)]++;
    if (r.give_up) give_ups++;
    pending_results.push_back(typed ? want : r);
    bytes_sent++;
  endtask

  // write a register once nothing is in flight
  task automatic write_reg(input logic idx, input logic [15:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_FRAME_LIMIT) frame_limit_reg = val[11:0];
    else fail_limit_reg = val;
  endtask

  function automatic row_t row_cfg(input logic idx, input logic [15:0] val);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic row_t row_any(input logic [7:0] b);
    row_t r;
    r = '0;
    r.b = b;
    return r;
  endfunction

  function automatic row_t row_hit(input logic [7:0] b, input logic sv, input logic [11:0] addr,
                                   input event_t ev, input logic [11:0] flen, input logic gu);
    row_t r;
    r = '0;
    r.b = b;
    r.typed = 1'b1;
    r.want.store_valid = sv;
    r.want.store_addr = addr;
    r.want.store_byte = sv ? b : 8'h00;
    r.want.event_res = ev;
    r.want.frame_length = flen;
    r.want.give_up = gu;
    return r;
  endfunction

  // one random stretch of traffic: mostly frames with random content, some noise
  task automatic random_segment();
    int kind;
    int body_len;
    int lim;
    kind = $urandom_range(0, 99);
    lim = eff_limit();
    body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 5);
    if (kind < 15) begin
      repeat ($urandom_range(1, 4)) send_item(8'($urandom_range(0, 255)));
    end else if (kind < 25 && lim <= 40) begin
      // fill the body to the limit, then one byte too many
      send_item(CH_OPEN);
      repeat (lim - 1) send_item(pick_byte_except(CH_BANG));
      send_item(8'($urandom_range(0, 255)));
    end else begin
      send_item(CH_OPEN);
      repeat (body_len) send_item(pick_byte_except(CH_BANG));
      send_item(CH_BANG);
      if (kind < 45) begin
        send_item(CH_CR);
        send_item(8'($urandom_range(0, 255)));
      end else if (kind < 85) begin
        send_item(pick_byte_except(CH_CR));
        repeat (3) send_item(8'($urandom_range(0, 255)));
        send_item((kind < 75) ? CH_CR : pick_byte_except(CH_CR));
        send_item(8'($urandom_range(0, 255)));
      end else begin
        // cut the tail short; the next bytes land in it
        repeat ($urandom_range(0, 4)) send_item(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (mismatches < REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // compare each accepted result with the oldest expectation; stall at random
  always @(posedge clk) begin : receive_side
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        if (mismatches < REPORT_CAP) $error("result with no request waiting");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("store_valid", want.store_valid, store_valid);
        check_field("store_addr", want.store_addr, store_addr);
        check_field("store_byte", want.store_byte, store_byte);
        check_field("event_res", want.event_res, event_res);
        check_field("frame_length", want.frame_length, frame_length);
        check_field("give_up", want.give_up, give_up);
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // end the run when neither side moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int set_idx;
    int target;
    frame_limit_reg = FRAME_LIMIT_RST;
    fail_limit_reg = FAIL_LIMIT_RST;
    hunt_again(1'b1);
    send_idle_pct = 7;
    recv_stall_pct = 55;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: hunt noise, old, new and bad-tail frames, then overflow into give-up
    directed_rows = '{
      row_hit(8'h00, 1'b0, 12'd0, EV_NONE, 12'd0, 1'b0),
      row_hit(8'hFF, 1'b0, 12'd0, EV_NONE, 12'd0, 1'b0),
      row_hit(CH_OPEN, 1'b1, 12'd0, EV_NONE, 12'd0, 1'b0),
      row_hit(8'h41, 1'b1, 12'd1, EV_NONE, 12'd0, 1'b0),
      row_hit(CH_BANG, 1'b1, 12'd2, EV_NONE, 12'd0, 1'b0),
      row_hit(CH_CR, 1'b1, 12'd3, EV_NONE, 12'd0, 1'b0),
      row_hit(8'h0A, 1'b1, 12'd4, EV_OLD_DONE, 12'd5, 1'b0),
      row_hit(CH_OPEN, 1'b1, 12'd0, EV_NONE, 12'd0, 1'b0),
      row_hit(CH_BANG, 1'b1, 12'd1, EV_NONE, 12'd0, 1'b0),
      row_any(8'h80),
      row_any(CH_CR),
      row_any(8'h7F),
      row_any(8'h01),
      row_any(CH_CR),
      row_hit(8'hFE, 1'b1, 12'd7, EV_NEW_DONE, 12'd8, 1'b0),
      row_hit(CH_OPEN, 1'b1, 12'd0, EV_NONE, 12'd0, 1'b0),
      row_any(8'h55),
      row_any(CH_BANG),
      row_any(8'hAA),
      row_any(8'h00),
      row_any(8'hFF),
      row_any(CH_CR),
      row_any(8'h0E),
      row_hit(CH_CR, 1'b1, 12'd8, EV_BAD_TAIL, 12'd0, 1'b0),
      row_cfg(CFG_FRAME_LIMIT, 16'd1),
      row_cfg(CFG_FAIL_LIMIT, 16'd10),
      row_hit(CH_OPEN, 1'b1, 12'd0, EV_NONE, 12'd0, 1'b0),
      row_hit(CH_BANG, 1'b0, 12'd0, EV_OVERFLOW, 12'd0, 1'b1)
    };
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_reg(directed_rows[i].idx, directed_rows[i].val);
      else send_item(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].want);
    end

    // random traffic over three idling profiles and nine limit settings
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 55 : 0;
      recv_stall_pct = (mode == 0) ? 55 : (mode == 1) ? 7 : 0;
      for (int s = 0; s < 3; s++) begin
        set_idx = mode * 3 + s;
        write_reg(CFG_FRAME_LIMIT, FRAME_SETTINGS[set_idx]);
        write_reg(CFG_FAIL_LIMIT, FAIL_SETTINGS[set_idx]);
        target = bytes_sent + ITEMS_PER_SET;
        while (bytes_sent < target) random_segment();
      end
    end

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results for %0d bytes: %0d old and %0d new frames, %0d bad tails,",
             results_seen, bytes_sent, ev_tally[1], ev_tally[2], ev_tally[3]);
    $display("%0d overflows and %0d give-ups over %0d limit settings and three idling mixes.",
             ev_tally[4], give_ups, 9);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/p1df_pkg.sv
rtl/p1df_step.sv
rtl/p1_telegram_deframer_unit.sv
rtl/p1df_checker.sv
dv/tb_p1_telegram_deframer_unit.sv
